// ===== rtl/core/fpdp_pkg.sv =====
`default_nettype none

package fpdp_pkg;

    // field widths
    localparam int FREQ_W  = 32;
    localparam int REF_W   = 27;
    localparam int WORD_W  = 13;
    localparam int RATIO_W = 6;
    localparam int INTN_W  = 19;
    localparam int FRACO_W = 24;

    // fractional bits of the N value (16..24)
    localparam int FRAC_BITS = 24;

    // dividend = product << FRAC_BITS
    localparam int NUM_W = FREQ_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int REM_W = REF_W;

    localparam logic [REF_W-1:0] REF_RESET = REF_W'(50000000);

    // band edges in Hz
    localparam logic [FREQ_W-1:0] F_MIN   = 32'd25000000;
    localparam logic [FREQ_W-1:0] F_B0    = 32'd31250000;
    localparam logic [FREQ_W-1:0] F_B1    = 32'd62500000;
    localparam logic [FREQ_W-1:0] F_B2    = 32'd125000000;
    localparam logic [FREQ_W-1:0] F_B3    = 32'd200000000;
    localparam logic [FREQ_W-1:0] F_B4    = 32'd375000000;
    localparam logic [FREQ_W-1:0] F_B5    = 32'd750000000;
    localparam logic [FREQ_W-1:0] F_B6    = 32'd1500000000;
    localparam logic [FREQ_W-1:0] F_MAX   = 32'd3000000000;

    // divider register words
    localparam logic [WORD_W-1:0] WORD_DIV60 = 13'h1E10;
    localparam logic [WORD_W-1:0] WORD_DIV48 = 13'h1810;
    localparam logic [WORD_W-1:0] WORD_DIV24 = 13'h0C10;
    localparam logic [WORD_W-1:0] WORD_DIV12 = 13'h0610;
    localparam logic [WORD_W-1:0] WORD_DIV8  = 13'h0410;
    localparam logic [WORD_W-1:0] WORD_DIV4  = 13'h0210;
    localparam logic [WORD_W-1:0] WORD_DIV2  = 13'h0110;
    localparam logic [WORD_W-1:0] WORD_DIV1  = 13'h0090;
    localparam logic [WORD_W-1:0] WORD_OOR   = 13'h1E10;

    localparam logic [RATIO_W-1:0] RATIO_60  = 6'd60;
    localparam logic [RATIO_W-1:0] RATIO_48  = 6'd48;
    localparam logic [RATIO_W-1:0] RATIO_24  = 6'd24;
    localparam logic [RATIO_W-1:0] RATIO_12  = 6'd12;
    localparam logic [RATIO_W-1:0] RATIO_8   = 6'd8;
    localparam logic [RATIO_W-1:0] RATIO_4   = 6'd4;
    localparam logic [RATIO_W-1:0] RATIO_2   = 6'd2;
    localparam logic [RATIO_W-1:0] RATIO_1   = 6'd1;
    localparam logic [RATIO_W-1:0] RATIO_OOR = 6'd0;

    localparam logic [INTN_W-1:0]  INTN_MAX  = '1;
    localparam logic [FRACO_W-1:0] FRAC_SAT  = FRACO_W'((64'd1 << FRAC_BITS) - 64'd1);

    // classified request handed from front to back
    typedef struct packed {
        logic                oor;
        logic [WORD_W-1:0]   word;
        logic [RATIO_W-1:0]  ratio;
        logic [FREQ_W-1:0]   prod;   // freq * ratio, below 2^32 in range
    } fpdp_item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DONE
    } bk_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/fpdp_front.sv =====
`default_nettype none

module fpdp_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [fpdp_pkg::FREQ_W-1:0] s_axis_tdata,
    input  wire logic                        q_full,
    output logic                             q_push,
    output fpdp_pkg::fpdp_item_t             q_item
);
    import fpdp_pkg::*;

    logic [WORD_W-1:0]         word;
    logic [RATIO_W-1:0]        ratio;
    logic                      oor;
    logic [FREQ_W+RATIO_W-1:0] prod_full;
    logic                      busy_reg;
    logic                      busy_next;

    // band select: lower edge exclusive except the bottom band
    always_comb
    begin
        oor   = 1'b0;
        word  = WORD_OOR;
        ratio = RATIO_OOR;
        if (s_axis_tdata < F_MIN || s_axis_tdata > F_MAX)
        begin
            oor = 1'b1;
        end
        else if (s_axis_tdata <= F_B0)
        begin
            word  = WORD_DIV60;
            ratio = RATIO_60;
        end
        else if (s_axis_tdata <= F_B1)
        begin
            word  = WORD_DIV48;
            ratio = RATIO_48;
        end
        else if (s_axis_tdata <= F_B2)
        begin
            word  = WORD_DIV24;
            ratio = RATIO_24;
        end
        else if (s_axis_tdata <= F_B3)
        begin
            word  = WORD_DIV12;
            ratio = RATIO_12;
        end
        else if (s_axis_tdata <= F_B4)
        begin
            word  = WORD_DIV8;
            ratio = RATIO_8;
        end
        else if (s_axis_tdata <= F_B5)
        begin
            word  = WORD_DIV4;
            ratio = RATIO_4;
        end
        else if (s_axis_tdata <= F_B6)
        begin
            word  = WORD_DIV2;
            ratio = RATIO_2;
        end
        else
        begin
            word  = WORD_DIV1;
            ratio = RATIO_1;
        end
    end

    // 32x6 product, at most 3e9 for any in-range request
    assign prod_full = s_axis_tdata * ratio;

    // tready held low during reset
    assign busy_next     = 1'b0;
    assign s_axis_tready = !q_full && !busy_reg;
    assign q_push        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        q_item.oor   = oor;
        q_item.word  = word;
        q_item.ratio = ratio;
        q_item.prod  = prod_full[FREQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fpdp_queue.sv =====
`default_nettype none

module fpdp_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire fpdp_pkg::fpdp_item_t push_item,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      not_empty,
    output fpdp_pkg::fpdp_item_t      pop_item
);
    import fpdp_pkg::*;

    // two-entry FIFO
    fpdp_item_t  mem [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fpdp_divider.sv =====
`default_nettype none

module fpdp_divider (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_valid,
    input  wire fpdp_pkg::fpdp_item_t       q_item,
    output logic                            q_pop,
    input  wire logic [fpdp_pkg::REF_W-1:0] ref_freq_hz,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [63:0]                     m_axis_tdata,
    output logic [0:0]                      m_axis_tuser
);
    import fpdp_pkg::*;

    bk_state_t           state_reg;
    bk_state_t           state_next;

    logic [NUM_W-1:0]    num_reg;     // dividend shifting out, quotient shifting in
    logic [NUM_W-1:0]    num_next;
    logic [REM_W-1:0]    rem_reg;
    logic [REM_W-1:0]    rem_next;
    logic [REF_W-1:0]    div_reg;
    logic [REF_W-1:0]    div_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                oor_reg;
    logic                oor_next;
    logic [WORD_W-1:0]   word_reg;
    logic [WORD_W-1:0]   word_next;
    logic [RATIO_W-1:0]  ratio_reg;
    logic [RATIO_W-1:0]  ratio_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [WORD_W-1:0]   out_word_reg;
    logic [RATIO_W-1:0]  out_ratio_reg;
    logic [INTN_W-1:0]   out_intn_reg;
    logic [FRACO_W-1:0]  out_frac_reg;
    logic                out_oor_reg;

    logic [REM_W:0]      rem_shift;
    logic [REM_W:0]      diff;
    logic                fits;
    logic                out_free;
    logic                load_out;
    logic                sat;
    logic [INTN_W-1:0]   res_intn;
    logic [FRACO_W-1:0]  res_frac;

    assign out_free = !out_valid_reg || m_axis_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_item.oor ? BK_DONE : BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            BK_IDLE: q_pop    = q_valid;
            BK_RUN:  q_pop    = 1'b0;
            BK_DONE: load_out = out_free;
            default:
            begin
                q_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // one restoring step per cycle; a zero divisor gives all ones
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign diff      = rem_shift - {1'b0, div_reg};
    assign fits      = (rem_shift >= {1'b0, div_reg});

    always_comb
    begin
        num_next   = num_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        oor_next   = oor_reg;
        word_next  = word_reg;
        ratio_next = ratio_reg;
        if (q_pop)
        begin
            num_next   = {q_item.prod, {FRAC_BITS{1'b0}}};
            rem_next   = '0;
            div_next   = ref_freq_hz;
            cnt_next   = CNT_W'(NUM_W - 1);
            oor_next   = q_item.oor;
            word_next  = q_item.word;
            ratio_next = q_item.ratio;
        end
        else if (state_reg == BK_RUN)
        begin
            num_next = {num_reg[NUM_W-2:0], fits};
            rem_next = fits ? diff[REM_W-1:0] : rem_shift[REM_W-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // saturate when the integer part overflows its field
    assign sat = (num_reg[NUM_W-1:FRAC_BITS+INTN_W] != '0);

    always_comb
    begin
        if (oor_reg)
        begin
            res_intn = '0;
            res_frac = '0;
        end
        else if (sat)
        begin
            res_intn = INTN_MAX;
            res_frac = FRAC_SAT;
        end
        else
        begin
            res_intn = num_reg[FRAC_BITS+INTN_W-1:FRAC_BITS];
            res_frac = FRACO_W'(num_reg[FRAC_BITS-1:0]);
        end
    end

    assign out_valid_next = (out_valid_reg && !m_axis_tready) || load_out;

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        cnt_reg   <= cnt_next;
        oor_reg   <= oor_next;
        word_reg  <= word_next;
        ratio_reg <= ratio_next;
        if (load_out)
        begin
            out_word_reg  <= word_reg;
            out_ratio_reg <= oor_reg ? RATIO_OOR : ratio_reg;
            out_intn_reg  <= res_intn;
            out_frac_reg  <= res_frac;
            out_oor_reg   <= oor_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_frac_reg, out_intn_reg, out_ratio_reg, out_word_reg};
    assign m_axis_tuser  = out_oor_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fracn_pll_divider_planner_top.sv =====
// Fractional-N PLL divider planner. Each request on s_axis carries an output
// frequency in Hz (32 bits, unsigned). The block picks one of eight output
// divider bands between 25 and 3000 MHz, returns the band's divide ratio and
// divider register word, and computes floor(freq * ratio * 2^24 / ref) as a
// 19-bit integer N (saturated, with the fraction forced to all ones) and a
// 24-bit fraction. Requests outside 25..3000 MHz come back flagged in tuser,
// with ratio, N and fraction zero and word 0x1E10. Every request gives exactly
// one result. The reference (reset 50 MHz) is written through cfg_wr_en /
// cfg_wr_data and must only change while no request is in flight.
// An in-range request passes through the shared bit-serial divider in the
// back end: a load, 56 quotient bits at one bit per cycle, then a result
// load. Out-of-range requests bypass the quotient steps. A two-entry queue
// lets the front take new requests while the divider works and while a
// finished result waits on m_axis.

`default_nettype none

module fracn_pll_divider_planner_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: reference frequency in Hz
    input  wire logic        cfg_wr_en,
    input  wire logic [26:0] cfg_wr_data,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] freq_hz
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [12:0] divider_word, [18:13] divide_ratio,
                                             // [37:19] integer_n, [61:38] fraction_n
    output logic [0:0]       m_axis_tuser    // [0] out_of_range
);
    import fpdp_pkg::*;

    logic [REF_W-1:0] ref_reg;
    logic [REF_W-1:0] ref_next;

    fpdp_item_t       push_item;
    fpdp_item_t       pop_item;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;

    // reference register; the user writes it only between requests, not enforced
    assign ref_next = cfg_wr_en ? cfg_wr_data : ref_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= REF_RESET;
        end
        else
        begin
            ref_reg <= ref_next;
        end
    end

    // front: band select and ratio multiply
    fpdp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    // decoupling queue
    fpdp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (pop_item)
    );

    // back: bit-serial divide and result register
    fpdp_divider u_divider (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (pop_item),
        .q_pop         (q_pop),
        .ref_freq_hz   (ref_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/core/fpdp_checker.sv =====
`default_nettype none

module fpdp_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [63:0] m_axis_tdata,
    input  wire logic [0:0]  m_axis_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // out-of-range result has fixed fields
    a_oor: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
        m_axis_tdata[12:0] == 13'h1E10 && m_axis_tdata[61:13] == 49'd0)
        else $error("bad out-of-range result");

    // in-range ratio is one of the band ratios
    a_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
        m_axis_tdata[18:13] == 6'd60 || m_axis_tdata[18:13] == 6'd48 ||
        m_axis_tdata[18:13] == 6'd24 || m_axis_tdata[18:13] == 6'd12 ||
        m_axis_tdata[18:13] == 6'd8  || m_axis_tdata[18:13] == 6'd4  ||
        m_axis_tdata[18:13] == 6'd2  || m_axis_tdata[18:13] == 6'd1)
        else $error("bad divide ratio");

    // pad bits above the fraction stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[63:62] == 2'b00)
        else $error("nonzero pad bits");

endmodule

bind fracn_pll_divider_planner_top fpdp_checker u_fpdp_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Divider planner testbench.
// Requests carry an output frequency in Hz; each one must come back as
// exactly one plan (divider word, divide ratio, integer N, fraction, range
// flag). A predictor below works the plan out in exact 64-bit integer math
// with its own copy of the reference frequency. Every accepted request
// queues its plan, and every accepted result is checked against the oldest
// queued plan.
//
// Test order: band edges at the reset reference, then reference extremes
// (zero, one, all ones, a value that puts saturation between band ends),
// then three random traffic phases with different idle mixes and
// references, then a long receiver hold-off, then a drain pause.

module testbench;
    import fpdp_pkg::*;

    localparam int STALL_LIMIT    = 4000;   // cycles with no handshake at all
    localparam int HOLDOFF_CYCLES = 400;
    localparam int RANDOM_PER_REF = 120;
    localparam int MAX_GAP        = 50;
    localparam int MAX_REPORTS    = 10;
    localparam int SETTLE_CYCLES  = 80;

    localparam logic [REF_W-1:0] REF_ZERO     = '0;
    localparam logic [REF_W-1:0] REF_ONE      = REF_W'(1);
    localparam logic [REF_W-1:0] REF_ALL_ONES = '1;
    localparam logic [REF_W-1:0] REF_LOW      = REF_W'(1000000);
    localparam logic [REF_W-1:0] REF_HIGH     = REF_W'(100000000);
    // low enough that the bottom band fits in N and the top band saturates
    localparam logic [REF_W-1:0] REF_SPLIT    = REF_W'(5000);

    // one plan, packed in the same order as {tuser, tdata}
    typedef struct packed {
        logic                oor;
        logic [FRACO_W-1:0]  frac;
        logic [INTN_W-1:0]   intn;
        logic [RATIO_W-1:0]  ratio;
        logic [WORD_W-1:0]   word;
    } pll_plan_t;

    typedef struct {
        logic [FREQ_W-1:0] freq;
        pll_plan_t         plan;
    } pending_plan_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_wr_en     = 1'b0;
    logic [REF_W-1:0]   cfg_wr_data   = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata  = '0;     // [31:0] freq_hz
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [63:0]        m_axis_tdata;           // [12:0] word, [18:13] ratio,
                                                // [37:19] integer_n, [61:38] fraction_n
    logic [0:0]         m_axis_tuser;           // [0] out_of_range

    // predictor copy of the reference register
    logic [REF_W-1:0]   ref_hz_model  = REF_RESET;
    pending_plan_t      awaited_plans[$];
    int                 fault_count   = 0;
    int                 src_idle_pct  = 0;
    int                 snk_idle_pct  = 0;
    int                 holdoff_req   = 0;      // picked up by the result sink
    pll_plan_t          seen_plan;
    pending_plan_t      oldest;

    fracn_pll_divider_planner_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Band boundaries: 25 MHz (inclusive low end), then the upper end of each
    // band, inclusive.
    function automatic logic [FREQ_W-1:0] band_edge(input int idx);
        begin
            case (idx)
                0:       return F_MIN;
                1:       return F_B0;
                2:       return F_B1;
                3:       return F_B2;
                4:       return F_B3;
                5:       return F_B4;
                6:       return F_B5;
                7:       return F_B6;
                default: return F_MAX;
            endcase
        end
    endfunction

    // Expected plan for one request at a given reference.
    function automatic pll_plan_t plan_divider(input logic [FREQ_W-1:0] freq,
                                               input logic [REF_W-1:0]  ref_hz);
        pll_plan_t   p;
        logic [63:0] dividend;
        logic [63:0] quotient;
        logic [63:0] int_part;
        begin
            p = '0;
            if (freq >= F_MIN && freq <= F_B0)
            begin
                p.ratio = RATIO_60;
                p.word  = WORD_DIV60;
            end
            else if (freq > F_B0 && freq <= F_B1)
            begin
                p.ratio = RATIO_48;
                p.word  = WORD_DIV48;
            end
            else if (freq > F_B1 && freq <= F_B2)
            begin
                p.ratio = RATIO_24;
                p.word  = WORD_DIV24;
            end
            else if (freq > F_B2 && freq <= F_B3)
            begin
                p.ratio = RATIO_12;
                p.word  = WORD_DIV12;
            end
            else if (freq > F_B3 && freq <= F_B4)
            begin
                p.ratio = RATIO_8;
                p.word  = WORD_DIV8;
            end
            else if (freq > F_B4 && freq <= F_B5)
            begin
                p.ratio = RATIO_4;
                p.word  = WORD_DIV4;
            end
            else if (freq > F_B5 && freq <= F_B6)
            begin
                p.ratio = RATIO_2;
                p.word  = WORD_DIV2;
            end
            else if (freq > F_B6 && freq <= F_MAX)
            begin
                p.ratio = RATIO_1;
                p.word  = WORD_DIV1;
            end
            else
            begin
                p.ratio = RATIO_OOR;
                p.word  = WORD_OOR;
                p.oor   = 1'b1;
            end

            if (!p.oor)
            begin
                // freq * ratio stays below 2^32, so the dividend fits in 56 bits
                dividend = (64'(freq) * 64'(p.ratio)) << FRAC_BITS;
                // zero reference: divider answers all ones
                quotient = (ref_hz == REF_ZERO) ? '1 : dividend / 64'(ref_hz);
                int_part = quotient >> FRAC_BITS;
                if (int_part > 64'(INTN_MAX))
                begin
                    p.intn = INTN_MAX;
                    p.frac = FRAC_SAT;
                end
                else
                begin
                    p.intn = INTN_W'(int_part);
                    p.frac = FRACO_W'(quotient & ((64'd1 << FRAC_BITS) - 64'd1));
                end
            end
            return p;
        end
    endfunction

    // Random frequency, weighted toward in-band values and band edges.
    function automatic logic [FREQ_W-1:0] pick_freq();
        int kind;
        int band;
        begin
            kind = $urandom_range(99);
            band = $urandom_range(7);
            if (kind < 60)
                return $urandom_range(band_edge(band + 1), band_edge(band));
            else if (kind < 75)
                return band_edge($urandom_range(8)) + $urandom_range(2) - 1;
            else if (kind < 85)
                return $urandom;
            else if (kind < 95)
                return $urandom_range(F_MIN - 1, 0);
            else
                return $urandom_range(32'hFFFF_FFFF, F_MAX + 1);
        end
    endfunction

    // Offer one request, with a random gap in front when the sender idles.
    // tvalid is left high on return so the next request can follow directly.
    task automatic send_request(input logic [FREQ_W-1:0] freq);
        int            gap;
        pending_plan_t entry;
        begin
            gap = 0;
            while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct)
                gap++;
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= freq;
            do
                @(posedge clk);
            while (!s_axis_tready);
            entry.freq = freq;
            entry.plan = plan_divider(freq, ref_hz_model);
            awaited_plans.push_back(entry);
        end
    endtask

    // Stop offering and wait until every queued plan has been checked.
    task automatic drain_results();
        begin
            s_axis_tvalid <= 1'b0;
            while (awaited_plans.size() != 0)
                @(posedge clk);
        end
    endtask

    // Reference write; only called with nothing in flight.
    task automatic set_reference(input logic [REF_W-1:0] ref_hz);
        begin
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= ref_hz;
            @(posedge clk);
            cfg_wr_en    <= 1'b0;
            ref_hz_model = ref_hz;
        end
    endtask

    // Every band boundary and the step just past it, at the reset reference.
    task automatic test_band_edges();
        begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
            send_request('0);
            send_request(F_MIN - 1);
            for (int i = 0; i <= 8; i++)
            begin
                send_request(band_edge(i));
                send_request(band_edge(i) + 1);
            end
            send_request('1);
            drain_results();
        end
    endtask

    // Zero reference, tiny references (saturation) and the widest one.
    task automatic test_reference_extremes();
        begin
            set_reference(REF_ZERO);
            send_request(F_B6);
            send_request('0);
            drain_results();
            set_reference(REF_ONE);
            send_request(F_MAX);
            drain_results();
            set_reference(REF_ALL_ONES);
            send_request(F_MIN);
            drain_results();
            set_reference(REF_SPLIT);
            send_request(F_MIN);
            send_request(F_MAX);
            drain_results();
        end
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                       input logic [REF_W-1:0] ref_a,
                                       input logic [REF_W-1:0] ref_b);
        begin
            src_idle_pct = src_pct;
            snk_idle_pct = snk_pct;
            set_reference(ref_a);
            repeat (RANDOM_PER_REF) send_request(pick_freq());
            drain_results();
            set_reference(ref_b);
            repeat (RANDOM_PER_REF) send_request(pick_freq());
            drain_results();
        end
    endtask

    // Receiver holds off while the sender keeps pushing, so the internal
    // queue fills and s_axis_tready has to drop.
    task automatic test_result_holdoff();
        begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
            holdoff_req  = HOLDOFF_CYCLES;
            repeat (12) send_request(pick_freq());
            drain_results();
        end
    endtask

    // Sender stops until every result is back, then resumes.
    task automatic test_drain_pause();
        begin
            src_idle_pct = 22;
            snk_idle_pct = 22;
            repeat (8) send_request(pick_freq());
            drain_results();
            repeat (8) send_request(pick_freq());
            drain_results();
        end
    endtask

    // Result sink: random stalls, or a counted hold-off when one is requested.
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (holdoff_req != 0)
            begin
                hold_left   = holdoff_req;
                holdoff_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= rst_n && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Result check: compare against the oldest queued plan.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_plan = pll_plan_t'({m_axis_tuser, m_axis_tdata[$bits(pll_plan_t)-2:0]});
            if (awaited_plans.size() == 0)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("unexpected result: word=%h ratio=%0d n=%0d frac=%h oor=%b",
                             seen_plan.word, seen_plan.ratio, seen_plan.intn,
                             seen_plan.frac, seen_plan.oor);
            end
            else
            begin
                oldest = awaited_plans.pop_front();
                if (seen_plan.word !== oldest.plan.word ||
                    seen_plan.ratio !== oldest.plan.ratio ||
                    seen_plan.intn !== oldest.plan.intn ||
                    seen_plan.frac !== oldest.plan.frac ||
                    seen_plan.oor !== oldest.plan.oor)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                    begin
                        $display("mismatch for freq %0d Hz:", oldest.freq);
                        $display("  expected word=%h ratio=%0d n=%0d frac=%h oor=%b",
                                 oldest.plan.word, oldest.plan.ratio, oldest.plan.intn,
                                 oldest.plan.frac, oldest.plan.oor);
                        $display("  actual   word=%h ratio=%0d n=%0d frac=%h oor=%b",
                                 seen_plan.word, seen_plan.ratio, seen_plan.intn,
                                 seen_plan.frac, seen_plan.oor);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any handshake on either side.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("fracn_pll_divider_planner_top verification failed");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first requests run at the reset reference, no write yet
        test_band_edges();
        test_reference_extremes();
        test_random_traffic(22, 64, REF_LOW, REF_W'($urandom_range(100000000, 1000000)));
        test_random_traffic(64, 22, REF_HIGH, REF_W'($urandom_range(100000000, 1000000)));
        test_random_traffic(0, 0, REF_W'($urandom_range(100000000, 1000000)), REF_RESET);
        test_result_holdoff();
        test_drain_pause();

        drain_results();
        // catch any stray result after the last expected one
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0 && awaited_plans.size() == 0)
            $display("fracn_pll_divider_planner_top verification clean");
        else
            $display("fracn_pll_divider_planner_top verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/fpdp_pkg.sv
rtl/core/fpdp_front.sv
rtl/core/fpdp_queue.sv
rtl/core/fpdp_divider.sv
rtl/core/fracn_pll_divider_planner_top.sv
rtl/core/fpdp_checker.sv
tb/testbench.sv
